@@ sv/keg_pkg.sv @@
// Shared types and constants of the keypad event generator.
package keg_pkg;

    typedef enum logic [2:0] {
        EV_KEY_DOWN   = 3'd0,
        EV_KEY_UP     = 3'd1,
        EV_REPEAT     = 3'd2,
        EV_LONG_PRESS = 3'd3,
        EV_IDLE       = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] key_mask;
        logic       last_event;
    } t_event;

    typedef struct packed {
        logic [7:0]  prev_keys;
        logic [31:0] long_dl;
        logic [31:0] repeat_dl;
        logic [31:0] idle_dl;
    } t_state;

    typedef struct packed {
        logic [15:0] long_press_delay;
        logic [15:0] repeat_delay;
        logic [31:0] idle_delay;
    } t_cfg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_REPEAT     = 2'd1;
    localparam logic [1:0] REG_IDLE       = 2'd2;

    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [15:0] REPEAT_RST     = 16'd250;
    localparam logic [31:0] IDLE_RST       = 32'd60000;

endpackage

@@ sv/keg_in_if.sv @@
// Input channel carrying one key port sample per word.
interface keg_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  port_raw;
    logic        read_failed;
    logic [31:0] now;

    modport source (output valid, output port_raw, output read_failed, output now,
                    input ready);
    modport sink (input valid, input port_raw, input read_failed, input now,
                  output ready);
endinterface

@@ sv/keg_out_if.sv @@
// Output channel carrying one key event per word.
interface keg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] key_mask;
    logic       last_event;

    modport source (output valid, output event_kind, output key_mask, output last_event,
                    input ready);
    modport sink (input valid, input event_kind, input key_mask, input last_event,
                  output ready);
endinterface

@@ sv/keg_step.sv @@
// Event decision and next-state logic for one key port sample.
module keg_step (
    input  logic [7:0]      i_port_raw,
    input  logic            i_read_failed,
    input  logic [31:0]     i_now,
    input  keg_pkg::t_state i_state,
    input  keg_pkg::t_cfg   i_cfg,
    output keg_pkg::t_state o_state,
    output keg_pkg::t_event o_ev0,
    output keg_pkg::t_event o_ev1,
    output logic [1:0]      o_count
);

    logic [7:0]  keys;
    logic [7:0]  added;
    logic [7:0]  gone;
    logic        same;
    logic        idle_hit;
    logic        rep_hit;
    logic        long_hit;
    logic [31:0] long_arm;
    logic [31:0] rep_arm;
    logic [31:0] idle_arm;

    assign keys     = ~i_port_raw;
    assign added    = keys & ~i_state.prev_keys;
    assign gone     = i_state.prev_keys & ~keys;
    assign same     = (keys == i_state.prev_keys);
    assign idle_hit = (i_now >= i_state.idle_dl);
    assign rep_hit  = (i_state.repeat_dl != 32'd0) && (i_now >= i_state.repeat_dl);
    assign long_hit = (i_state.long_dl != 32'd0) && (i_now >= i_state.long_dl);
    assign long_arm = i_now + {16'd0, i_cfg.long_press_delay};
    assign rep_arm  = i_now + {16'd0, i_cfg.repeat_delay};
    assign idle_arm = i_now + i_cfg.idle_delay;

    always_comb begin
        o_state = i_state;
        o_count = 2'd0;
        o_ev0   = '{kind: keg_pkg::EV_IDLE, key_mask: 8'd0, last_event: 1'b1};
        o_ev1   = '{kind: keg_pkg::EV_LONG_PRESS, key_mask: keys, last_event: 1'b1};
        if (i_read_failed) begin
            o_count = 2'd0;
        end else if (same) begin
            if (keys == 8'd0) begin
                if (idle_hit) begin
                    o_count         = 2'd1;
                    o_state.idle_dl = idle_arm;
                end
            end else begin
                if (rep_hit) begin
                    o_state.repeat_dl = rep_arm;
                end
                if (long_hit) begin
                    o_state.long_dl = 32'd0;
                end
                if (rep_hit && long_hit) begin
                    o_count = 2'd2;
                    o_ev0   = '{kind: keg_pkg::EV_REPEAT, key_mask: keys, last_event: 1'b0};
                end else if (rep_hit) begin
                    o_count = 2'd1;
                    o_ev0   = '{kind: keg_pkg::EV_REPEAT, key_mask: keys, last_event: 1'b1};
                end else if (long_hit) begin
                    o_count = 2'd1;
                    o_ev0   = '{kind: keg_pkg::EV_LONG_PRESS, key_mask: keys, last_event: 1'b1};
                end
            end
        end else begin
            o_count           = 2'd1;
            o_state.idle_dl   = idle_arm;
            o_state.prev_keys = keys;
            if ((i_state.prev_keys == 8'd0) || (added != 8'd0)) begin
                o_state.long_dl   = long_arm;
                o_state.repeat_dl = rep_arm;
                o_ev0 = '{kind: keg_pkg::EV_KEY_DOWN, key_mask: keys, last_event: 1'b1};
            end else begin
                o_state.long_dl   = 32'd0;
                o_state.repeat_dl = 32'd0;
                o_ev0 = '{kind: keg_pkg::EV_KEY_UP, key_mask: gone, last_event: 1'b1};
            end
        end
    end

endmodule

@@ sv/keypad_event_generator.sv @@
// Top level of the keypad event generator with its register port and output stage.
//
// Each input word is one sample of the active-low key port with a read-failed
// flag and a time stamp. The block answers with zero, one or two event words
// (key down, key up, auto repeat, long press, inactivity); the final word of a
// sample carries last_event. A failed read yields no word and changes nothing.
// A sample is captured in an input register and then decided by one level of
// add-and-compare logic that writes the output register, from which the event
// words are driven. A new sample is accepted every cycle while each sample
// yields at most one word and the receiver keeps ready high; a sample that
// yields two words holds the input side while the second word waits in a spare
// register. When the receiver stalls, words stay in the output register and
// the spare register, and the input register fills before ready drops.
// The user must write the delays over the register port only while the block is
// idle; the block itself does not enforce this. Reset clears the key history,
// disarms the long-press and repeat deadlines, zeroes the idle deadline, loads the
// default delays (1000, 250 and 60000 ticks) and empties the input and output stages.
module keypad_event_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    keg_in_if.sink                     i_in,
    keg_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [keg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    keg_pkg::t_cfg   r_cfg;
    keg_pkg::t_state r_state;
    keg_pkg::t_state n_state;
    keg_pkg::t_event ev0;
    keg_pkg::t_event ev1;
    logic [1:0]      ev_count;

    logic            r_in_valid;
    logic [7:0]      r_port_raw;
    logic            r_read_failed;
    logic [31:0]     r_now;

    logic            r_out_valid;
    keg_pkg::t_event r_out;
    logic            r_spare_valid;
    keg_pkg::t_event r_spare;

    logic            pop;
    logic            proc;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_delay <= keg_pkg::LONG_PRESS_RST;
            r_cfg.repeat_delay     <= keg_pkg::REPEAT_RST;
            r_cfg.idle_delay       <= keg_pkg::IDLE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                keg_pkg::REG_LONG_PRESS: r_cfg.long_press_delay <= pwdata[15:0];
                keg_pkg::REG_REPEAT:     r_cfg.repeat_delay     <= pwdata[15:0];
                keg_pkg::REG_IDLE:       r_cfg.idle_delay       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            keg_pkg::REG_LONG_PRESS: prdata = {16'd0, r_cfg.long_press_delay};
            keg_pkg::REG_REPEAT:     prdata = {16'd0, r_cfg.repeat_delay};
            keg_pkg::REG_IDLE:       prdata = r_cfg.idle_delay;
            default:                 prdata = 32'd0;
        endcase
    end

    assign pop        = r_out_valid && o_out.ready;
    assign proc       = r_in_valid && !r_spare_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_port_raw    <= i_in.port_raw;
            r_read_failed <= i_in.read_failed;
            r_now         <= i_in.now;
        end
    end

    keg_step u_step (
        .i_port_raw    (r_port_raw),
        .i_read_failed (r_read_failed),
        .i_now         (r_now),
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .o_state       (n_state),
        .o_ev0         (ev0),
        .o_ev1         (ev1),
        .o_count       (ev_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid   <= (ev_count != 2'd0);
            r_spare_valid <= (ev_count == 2'd2);
        end else if (pop) begin
            r_out_valid   <= r_spare_valid;
            r_spare_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out   <= ev0;
            r_spare <= ev1;
        end else if (pop) begin
            r_out   <= r_spare;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out.kind;
    assign o_out.key_mask   = r_out.key_mask;
    assign o_out.last_event = r_out.last_event;

endmodule

@@ dv/keypad_event_generator_tb.sv @@
// Self-checking testbench of the keypad event generator with a built-in event predictor.
module keypad_event_generator_tb;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

    typedef struct packed {
        logic [7:0]  port_raw;
        logic        read_failed;
        logic [31:0] now;
    } t_sample;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [keg_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    keg_in_if  in_if ();
    keg_out_if out_if ();

    keypad_event_generator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_sample          sample_queue[$];
    keg_pkg::t_event  event_forecast[$];
    logic             in_holding;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               mismatches;
    int               stall_cycles;
    logic [31:0]      clock_ticks;

    keg_pkg::t_cfg    delays;
    logic [7:0]       held_keys;
    logic [31:0]      long_dl;
    logic [31:0]      repeat_dl;
    logic [31:0]      idle_dl;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic keg_pkg::t_event key_event(input keg_pkg::t_kind kind,
                                                  input logic [7:0] mask);
        keg_pkg::t_event ev;
        ev.kind       = kind;
        ev.key_mask   = mask;
        ev.last_event = 1'b0;
        return ev;
    endfunction

    task automatic predict_events(input t_sample s);
        logic [7:0]      keys;
        keg_pkg::t_event burst[$];
        keys = ~s.port_raw;
        if (s.read_failed) begin
            return;
        end
        if (keys == held_keys) begin
            if (keys == 8'd0) begin
                if (s.now >= idle_dl) begin
                    burst.push_back(key_event(keg_pkg::EV_IDLE, 8'd0));
                    idle_dl = s.now + delays.idle_delay;
                end
            end else begin
                if (repeat_dl != 32'd0 && s.now >= repeat_dl) begin
                    repeat_dl = s.now + 32'(delays.repeat_delay);
                    burst.push_back(key_event(keg_pkg::EV_REPEAT, keys));
                end
                if (long_dl != 32'd0 && s.now >= long_dl) begin
                    long_dl = 32'd0;
                    burst.push_back(key_event(keg_pkg::EV_LONG_PRESS, keys));
                end
            end
        end else begin
            if (held_keys == 8'd0 || (keys & ~held_keys) != 8'd0) begin
                long_dl   = s.now + 32'(delays.long_press_delay);
                repeat_dl = s.now + 32'(delays.repeat_delay);
                burst.push_back(key_event(keg_pkg::EV_KEY_DOWN, keys));
            end else begin
                long_dl   = 32'd0;
                repeat_dl = 32'd0;
                burst.push_back(key_event(keg_pkg::EV_KEY_UP, held_keys & ~keys));
            end
            idle_dl   = s.now + delays.idle_delay;
            held_keys = keys;
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last_event = 1'b1;
        end
        foreach (burst[k]) begin
            event_forecast.push_back(burst[k]);
        end
    endtask

    always @(negedge clk) begin
        if (rst_n && !in_holding) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_if.valid       <= 1'b1;
                in_if.port_raw    <= sample_queue[0].port_raw;
                in_if.read_failed <= sample_queue[0].read_failed;
                in_if.now         <= sample_queue[0].now;
                in_holding        <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        if (rst_n) begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready) begin
            predict_events(sample_queue[0]);
            void'(sample_queue.pop_front());
            in_holding <= 1'b0;
        end
    end

    always @(posedge clk) begin
        keg_pkg::t_event want;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (event_forecast.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected event word: kind %0d mask %h last %0b",
                                 out_if.event_kind, out_if.key_mask, out_if.last_event);
                    end
                end else begin
                    want = event_forecast.pop_front();
                    if (out_if.event_kind !== want.kind || out_if.key_mask !== want.key_mask
                        || out_if.last_event !== want.last_event) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: exp %0d %h %0b got %0d %h %0b",
                                     want.kind, want.key_mask, want.last_event,
                                     out_if.event_kind, out_if.key_mask, out_if.last_event);
                        end
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (psel && penable)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("keypad_event_generator_tb: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic queue_sample(input logic [7:0] raw, input logic failed, input logic [31:0] now);
        t_sample s;
        s.port_raw    = raw;
        s.read_failed = failed;
        s.now         = now;
        sample_queue.push_back(s);
    endtask

    task automatic settle();
        while (sample_queue.size() != 0 || event_forecast.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        case (index)
            keg_pkg::REG_LONG_PRESS: delays.long_press_delay = value[15:0];
            keg_pkg::REG_REPEAT:     delays.repeat_delay     = value[15:0];
            keg_pkg::REG_IDLE:       delays.idle_delay       = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sessions mostly press, hold, extend and release key sets with rising time,
    // mixed with random port noise and failed reads.
    task automatic queue_session(input int count, input int step_max);
        logic [7:0]  keys;
        int unsigned pick;
        keys = 8'd0;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                if ($urandom_range(1) == 0) begin
                    queue_sample(8'($urandom), 1'($urandom), $urandom);
                end else begin
                    queue_sample(8'($urandom), 1'($urandom), clock_ticks);
                end
            end else begin
                if (pick < 55) begin
                    keys = keys;
                end else if (pick < 68) begin
                    keys = keys | (8'd1 << $urandom_range(7));
                end else if (pick < 80) begin
                    keys = keys & 8'($urandom);
                end else if (pick < 90) begin
                    keys = 8'd0;
                end else begin
                    keys = 8'($urandom);
                end
                clock_ticks = clock_ticks + $urandom_range(step_max);
                queue_sample(~keys, $urandom_range(99) < 4, clock_ticks);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] long_press, input logic [31:0] repeat_gap,
                             input logic [31:0] idle_gap, input logic [31:0] start,
                             input int count, input int step_max);
        settle();
        write_reg(keg_pkg::REG_LONG_PRESS, long_press);
        write_reg(keg_pkg::REG_REPEAT, repeat_gap);
        write_reg(keg_pkg::REG_IDLE, idle_gap);
        clock_ticks = start;
        queue_session(count, step_max);
    endtask

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.port_raw    = 8'hFF;
        in_if.read_failed = 1'b0;
        in_if.now         = 32'd0;
        out_if.ready      = 1'b0;
        in_holding        = 1'b0;
        mismatches        = 0;
        stall_cycles      = 0;
        clock_ticks       = 32'd0;
        delays.long_press_delay = keg_pkg::LONG_PRESS_RST;
        delays.repeat_delay     = keg_pkg::REPEAT_RST;
        delays.idle_delay       = keg_pkg::IDLE_RST;
        held_keys         = 8'd0;
        long_dl           = 32'd0;
        repeat_dl         = 32'd0;
        idle_dl           = 32'd0;
        tx_idle_pct       = 6;
        rx_idle_pct       = 88;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_sample(8'h00, 1'b1, 32'd5);
        queue_sample(8'hFF, 1'b0, 32'd0);
        queue_sample(8'hFF, 1'b0, 32'd59999);
        queue_sample(8'hFF, 1'b0, 32'd60000);
        queue_sample(8'hFE, 1'b0, 32'd60010);
        queue_sample(8'hFE, 1'b0, 32'd60260);
        queue_sample(8'hFC, 1'b0, 32'd60300);
        queue_sample(8'hFC, 1'b0, 32'd61300);
        queue_sample(8'hFD, 1'b0, 32'd61301);
        queue_sample(8'hFF, 1'b0, 32'd61302);
        queue_sample(8'h00, 1'b0, 32'hFFFF_FC18);
        queue_sample(8'h00, 1'b0, 32'hFFFF_FFFF);
        queue_sample(8'h00, 1'b1, 32'hFFFF_FFFF);
        queue_sample(8'h7F, 1'b0, 32'd100);
        queue_sample(8'hFF, 1'b0, 32'd200);
        queue_sample(8'hFF, 1'b0, 32'hFFFF_FFFF);
        clock_ticks = 32'd300;
        queue_session(100, 300);

        settle();
        write_reg(REG_UNMAPPED, $urandom);
        run_phase(32'd0, 32'd0, 32'd0, $urandom, 120, 3);
        run_phase($urandom_range(1, 60), $urandom_range(1, 25), $urandom_range(1, 200),
                  $urandom, 130, 20);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000, 130, 40000);

        settle();
        tx_idle_pct = 88;
        rx_idle_pct = 6;
        for (int p = 0; p < 3; p++) begin
            run_phase($urandom_range(1, 60), $urandom_range(1, 25), $urandom_range(1, 200),
                      $urandom, 130, 20);
        end
        run_phase($urandom, $urandom, $urandom, $urandom, 130, 50000);

        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int p = 0; p < 3; p++) begin
            run_phase($urandom_range(0, 60), $urandom_range(0, 25), $urandom_range(0, 200),
                      $urandom, 135, 20);
        end
        run_phase(32'(keg_pkg::LONG_PRESS_RST), 32'(keg_pkg::REPEAT_RST), 32'd2000,
                  $urandom, 135, 300);

        settle();
        if (mismatches == 0 && event_forecast.size() == 0) begin
            $display("keypad_event_generator_tb: PASS");
        end else begin
            $display("keypad_event_generator_tb: FAIL");
        end
        $finish;
    end

endmodule
